// ===== src/rtcfe_pkg.sv =====
// rtcfe_pkg: shared types, constants and the field decode function for the
// RTC-fields-to-epoch-seconds pipeline. No dependencies.
`timescale 1ns / 1ps

package rtcfe_pkg;

   // Calendar constants (civil-to-days with 400-year eras, March-based year)
   localparam int DAYS_PER_ERA  = 146097;
   localparam int EPOCH_SHIFT   = 719468;
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int MONTH_COEF    = 153;

   // Day number of 2000-03-01 and of 1999-03-01 relative to 1970-01-01
   localparam int DAYS_2000 = 5 * DAYS_PER_ERA - EPOCH_SHIFT;
   localparam int DAYS_1999 = 4 * DAYS_PER_ERA - EPOCH_SHIFT
                              + 399 * 365 + 399 / 4 - 399 / 100;

   // x / 5 as (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 81920
   localparam int DIV5_MUL   = 52429;
   localparam int DIV5_SHIFT = 18;

   localparam int FIELD_W = 8;   // raw and decoded field width
   localparam int M153_W  = 16;  // 153 * mp + 2
   localparam int QUOT_W  = 13;  // (153 * mp + 2) / 5
   localparam int DAYS_W  = 17;  // day count, always positive
   localparam int HMS_W   = 20;  // hour/minute/second part in seconds
   localparam int EPOCH_W = 34;  // result width

   localparam logic [FIELD_W-1:0] FIRST_MARCH_MONTH = 8'd3;

   // Decoded clock fields plus valid, first pipeline stage output
   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] second;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] year;
   } dec_fields_type;

   // Day count and time-of-day seconds plus valid
   typedef struct packed {
      logic              valid;
      logic [DAYS_W-1:0] days;
      logic [HMS_W-1:0]  hms;
   } day_fields_type;

   // Field decode: raw byte in binary mode, else low nibble plus ten times high nibble (nibbles above 9 kept)
   function automatic logic [FIELD_W-1:0] field_decode(input logic [FIELD_W-1:0] raw,
                                                        input logic binary);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = raw[7:4];
      lo = raw[3:0];
      if (binary) begin
         return raw;
      end
      return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
   endfunction

endpackage

// ===== src/rtcfe_decode.sv =====
// rtcfe_decode: first pipeline stage, BCD or binary decode of the six fields.
// Depends on rtcfe_pkg.
`timescale 1ns / 1ps

module rtcfe_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    binary_mode,
   input  logic [7:0]              raw_second,
   input  logic [7:0]              raw_minute,
   input  logic [7:0]              raw_hour,
   input  logic [7:0]              raw_day,
   input  logic [7:0]              raw_month,
   input  logic [7:0]              raw_year,
   output rtcfe_pkg::dec_fields_type dec_out
);

   rtcfe_pkg::dec_fields_type dec_ff;
   rtcfe_pkg::dec_fields_type dec_in;

   // Decode each byte per mode
   always_comb begin
      dec_in.valid  = in_valid;
      dec_in.second = rtcfe_pkg::field_decode(raw_second, binary_mode);
      dec_in.minute = rtcfe_pkg::field_decode(raw_minute, binary_mode);
      dec_in.hour   = rtcfe_pkg::field_decode(raw_hour, binary_mode);
      dec_in.day    = rtcfe_pkg::field_decode(raw_day, binary_mode);
      dec_in.month  = rtcfe_pkg::field_decode(raw_month, binary_mode);
      dec_in.year   = rtcfe_pkg::field_decode(raw_year, binary_mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= '0;
      end else begin
         dec_ff <= dec_in;
      end
   end

   assign dec_out = dec_ff;

endmodule

// ===== src/rtcfe_days.sv =====
// rtcfe_days: three pipeline stages from decoded fields to the day count
// since 1970-01-01 and the time-of-day seconds. Depends on rtcfe_pkg.
`timescale 1ns / 1ps

module rtcfe_days (
   input  logic                      clock,
   input  logic                      reset,
   input  rtcfe_pkg::dec_fields_type dec_in,
   output rtcfe_pkg::day_fields_type day_out
);

   localparam int FW = rtcfe_pkg::FIELD_W;
   localparam int MW = rtcfe_pkg::M153_W;
   localparam int QW = rtcfe_pkg::QUOT_W;
   localparam int DW = rtcfe_pkg::DAYS_W;
   localparam int HW = rtcfe_pkg::HMS_W;

   // Stage A: month/year shift, year days, month numerator, hms
   logic          early_month;
   logic          year_1999;
   logic [FW-1:0] mp;
   logic [FW-1:0] yoe;
   logic [1:0]    cent;

   logic          va_ff,    va_in;
   logic [MW-1:0] m153_ff,  m153_in;
   logic [DW-1:0] yd_a_ff,  yd_a_in;
   logic [FW-1:0] day_a_ff;
   logic [HW-1:0] hms_a_ff, hms_a_in;

   always_comb begin
      early_month = dec_in.month < rtcfe_pkg::FIRST_MARCH_MONTH;
      mp          = early_month ? (dec_in.month + 8'd9) : (dec_in.month - 8'd3);
      year_1999   = early_month && (dec_in.year == '0);
      yoe         = early_month ? (dec_in.year - 8'd1) : dec_in.year;
      if (yoe >= 8'd200) begin
         cent = 2'd2;
      end else if (yoe >= 8'd100) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      va_in   = dec_in.valid;
      m153_in = MW'(mp) * MW'(rtcfe_pkg::MONTH_COEF) + MW'(2);
      if (year_1999) begin
         yd_a_in = DW'(rtcfe_pkg::DAYS_1999);
      end else begin
         yd_a_in = DW'(rtcfe_pkg::DAYS_2000) + DW'(yoe) * DW'(365)
                   + DW'(yoe[FW-1:2]) - DW'(cent);
      end
      hms_a_in = HW'(dec_in.hour) * HW'(rtcfe_pkg::SECS_PER_HOUR)
                 + HW'(dec_in.minute) * HW'(rtcfe_pkg::SECS_PER_MIN)
                 + HW'(dec_in.second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
      end
      m153_ff  <= m153_in;
      yd_a_ff  <= yd_a_in;
      day_a_ff <= dec_in.day;
      hms_a_ff <= hms_a_in;
   end

   // Stage B: divide month numerator by five through reciprocal multiply
   logic [31:0]   div_prod;
   logic          vb_ff;
   logic [QW-1:0] quot_ff,  quot_in;
   logic [DW-1:0] yd_b_ff;
   logic [FW-1:0] day_b_ff;
   logic [HW-1:0] hms_b_ff;

   always_comb begin
      div_prod = 32'(m153_ff) * 32'(rtcfe_pkg::DIV5_MUL);
      quot_in  = div_prod[rtcfe_pkg::DIV5_SHIFT +: QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      quot_ff  <= quot_in;
      yd_b_ff  <= yd_a_ff;
      day_b_ff <= day_a_ff;
      hms_b_ff <= hms_a_ff;
   end

   // Stage C: total day count (never negative, so modular add is exact)
   logic          vc_ff;
   logic [DW-1:0] days_ff, days_in;
   logic [HW-1:0] hms_c_ff;

   always_comb begin
      days_in = yd_b_ff + DW'(quot_ff) + DW'(day_b_ff) - DW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      days_ff  <= days_in;
      hms_c_ff <= hms_b_ff;
   end

   assign day_out.valid = vc_ff;
   assign day_out.days  = days_ff;
   assign day_out.hms   = hms_c_ff;

endmodule

// ===== src/rtcfe_secs.sv =====
// rtcfe_secs: two pipeline stages, day count times 86400, then the
// time-of-day seconds added. Depends on rtcfe_pkg.
`timescale 1ns / 1ps

module rtcfe_secs (
   input  logic                               clock,
   input  logic                               reset,
   input  rtcfe_pkg::day_fields_type          day_in,
   output logic                               out_valid,
   output logic [rtcfe_pkg::EPOCH_W-1:0]      out_seconds
);

   localparam int EW = rtcfe_pkg::EPOCH_W;
   localparam int HW = rtcfe_pkg::HMS_W;

   // Stage D: days to seconds
   logic          vd_ff;
   logic [EW-1:0] prod_ff, prod_in;
   logic [HW-1:0] hms_ff;

   always_comb begin
      prod_in = EW'(day_in.days) * EW'(rtcfe_pkg::SECS_PER_DAY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= day_in.valid;
      end
      prod_ff <= prod_in;
      hms_ff  <= day_in.hms;
   end

   // Stage E: final sum into the output register
   logic          ve_ff;
   logic [EW-1:0] total_ff, total_in;

   always_comb begin
      total_in = prod_ff + EW'(hms_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= vd_ff;
      end
      total_ff <= total_in;
   end

   assign out_valid   = ve_ff;
   assign out_seconds = total_ff;

endmodule

// ===== src/rtc_fields_to_epoch_seconds_unit.sv =====
// Converts six raw RTC register bytes (BCD or binary) into seconds since
// 1970-01-01 00:00:00. A new transaction may start in every clock cycle:
// busy is never raised, and each result appears on rsp_epoch_seconds with
// rsp_valid high for one cycle, in start order, after passing through the
// six-stage pipeline (decode, calendar terms, divide-by-five multiply, day
// sum, seconds-per-day multiply, final add). Results cannot be held off, so
// the receiver must take every one. csr_wdata selects binary fields (1) or
// BCD fields (0); write it only while no transaction is in flight. Depends
// on rtcfe_pkg and the rtcfe_decode, rtcfe_days and rtcfe_secs modules.
`timescale 1ns / 1ps

module rtc_fields_to_epoch_seconds_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_raw_second,
   input  logic [7:0]  req_raw_minute,
   input  logic [7:0]  req_raw_hour,
   input  logic [7:0]  req_raw_day,
   input  logic [7:0]  req_raw_month,
   input  logic [7:0]  req_raw_year,
   output logic        rsp_valid,
   output logic [33:0] rsp_epoch_seconds,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   // Mode register
   logic binary_mode_ff, binary_mode_in;

   always_comb begin
      binary_mode_in = csr_we ? csr_wdata : binary_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff <= 1'b0;
      end else begin
         binary_mode_ff <= binary_mode_in;
      end
   end

   // Fully pipelined, never stalls
   assign busy = 1'b0;

   rtcfe_pkg::dec_fields_type dec_fields;
   rtcfe_pkg::day_fields_type day_fields;

   rtcfe_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start & ~busy),
      .binary_mode (binary_mode_ff),
      .raw_second  (req_raw_second),
      .raw_minute  (req_raw_minute),
      .raw_hour    (req_raw_hour),
      .raw_day     (req_raw_day),
      .raw_month   (req_raw_month),
      .raw_year    (req_raw_year),
      .dec_out     (dec_fields)
   );

   rtcfe_days u_days (
      .clock   (clock),
      .reset   (reset),
      .dec_in  (dec_fields),
      .day_out (day_fields)
   );

   rtcfe_secs u_secs (
      .clock       (clock),
      .reset       (reset),
      .day_in      (day_fields),
      .out_valid   (rsp_valid),
      .out_seconds (rsp_epoch_seconds)
   );

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for rtc_fields_to_epoch_seconds_unit, RTC
// bytes in, epoch seconds out, in BCD and binary modes. Depends on the DUT only.
`timescale 1ns / 1ps

module testbench;

   // Calendar constants for the local epoch calculation
   localparam longint ERA_DAYS     = 146097;
   localparam longint SHIFT_DAYS   = 719468;
   localparam longint DAY_SECONDS  = 86400;
   localparam int     RANDOM_ITEMS = 320;   // per random phase
   localparam int     N_DIRECTED   = 19;
   localparam int     N_PHASES     = 5;
   localparam logic   MODE_BCD     = 1'b0;
   localparam logic   MODE_BINARY  = 1'b1;

   typedef struct packed {
      logic [7:0] second;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } clock_fields_type;

   // One directed row: mode, fields, and a typed-in epoch where it is obvious
   typedef struct packed {
      logic             binary;
      clock_fields_type fields;
      logic             has_known;
      logic [33:0]      known_epoch;
   } directed_row_type;

   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      // BCD: all zero is month 0 / day 0, i.e. 1999-11-30
      '{MODE_BCD, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 34'd943920000},
      '{MODE_BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1, 34'd946684800},
      '{MODE_BCD, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00}, 1'b1, 34'd951868800},
      '{MODE_BCD, '{8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38}, 1'b1, 34'd2147483647},
      '{MODE_BCD, '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99}, 1'b1, 34'd4102444799},
      // day zero of March is the leap day
      '{MODE_BCD, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00}, 1'b1, 34'd951782400},
      '{MODE_BCD, '{8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00}, 1'b0, 34'd0},
      // invalid BCD nibbles everywhere
      '{MODE_BCD, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 34'd0},
      '{MODE_BCD, '{8'h0F, 8'hA0, 8'h3C, 8'h1F, 8'h0A, 8'hF0}, 1'b0, 34'd0},
      // PM flag in the hour byte, month thirteen
      '{MODE_BCD, '{8'h30, 8'h45, 8'h92, 8'h15, 8'h13, 8'h24}, 1'b0, 34'd0},
      '{MODE_BCD, '{8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99}, 1'b0, 34'd0},
      '{MODE_BCD, '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20}, 1'b0, 34'd0},
      // binary mode
      '{MODE_BINARY, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 34'd943920000},
      '{MODE_BINARY, '{8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0}, 1'b1, 34'd946684800},
      '{MODE_BINARY, '{8'd7, 8'd14, 8'd3, 8'd19, 8'd1, 8'd38}, 1'b1, 34'd2147483647},
      '{MODE_BINARY, '{8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99}, 1'b1, 34'd4102444799},
      '{MODE_BINARY, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 34'd0},
      '{MODE_BINARY, '{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, 34'd0},
      '{MODE_BINARY, '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b0, 34'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_raw_second = '0;
   logic [7:0]  req_raw_minute = '0;
   logic [7:0]  req_raw_hour = '0;
   logic [7:0]  req_raw_day = '0;
   logic [7:0]  req_raw_month = '0;
   logic [7:0]  req_raw_year = '0;
   logic        rsp_valid;
   logic [33:0] rsp_epoch_seconds;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   // Typed-in expectation travels with the transaction
   logic        known_valid = 1'b0;
   logic [33:0] known_epoch = '0;

   logic        binary_shadow = MODE_BCD;
   logic [33:0] pending_epochs[$];
   int          mismatch_count = 0;
   int          burst_left = 1;

   rtc_fields_to_epoch_seconds_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_raw_second    (req_raw_second),
      .req_raw_minute    (req_raw_minute),
      .req_raw_hour      (req_raw_hour),
      .req_raw_day       (req_raw_day),
      .req_raw_month     (req_raw_month),
      .req_raw_year      (req_raw_year),
      .rsp_valid         (rsp_valid),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Field value: raw byte in binary mode, nibble-weighted otherwise
   function automatic longint field_value(input logic [7:0] raw, input logic binary);
      if (binary) begin
         return longint'(raw);
      end
      return longint'(raw[3:0]) + 10 * longint'(raw[7:4]);
   endfunction

   // Seconds since 1970-01-01 for one set of clock bytes
   function automatic logic [33:0] epoch_of_fields(input logic binary,
                                                   input clock_fields_type f);
      longint yr, mon, dy, era, yoe, mp, doy, doe, days, total;
      yr  = 2000 + field_value(f.year, binary);
      mon = field_value(f.month, binary);
      dy  = field_value(f.day, binary);
      // January, February and month zero belong to the previous March year
      if (mon <= 2) begin
         yr = yr - 1;
      end
      era = yr / 400;
      yoe = yr - era * 400;
      mp  = (mon > 2) ? (mon - 3) : (mon + 9);
      doy = (153 * mp + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * ERA_DAYS + doe - SHIFT_DAYS;
      total = days * DAY_SECONDS + field_value(f.hour, binary) * 3600
              + field_value(f.minute, binary) * 60 + field_value(f.second, binary);
      return total[33:0];
   endfunction

   function automatic logic [7:0] to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Mostly well-formed dates, some fields or whole items as raw noise
   function automatic clock_fields_type random_fields(input logic binary);
      clock_fields_type f;
      int vals [6];
      vals[0] = $urandom_range(0, 59);
      vals[1] = $urandom_range(0, 59);
      vals[2] = $urandom_range(0, 23);
      vals[3] = $urandom_range(1, 31);
      vals[4] = $urandom_range(1, 12);
      vals[5] = $urandom_range(0, 99);
      if ($urandom_range(0, 19) < 3) begin
         f = clock_fields_type'(48'({$urandom, $urandom}));
         return f;
      end
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            vals[i] = $urandom_range(0, 255);
         end else if (!binary) begin
            vals[i] = int'(to_bcd(vals[i]));
         end
      end
      f.second = 8'(vals[0]);
      f.minute = 8'(vals[1]);
      f.hour   = 8'(vals[2]);
      f.day    = 8'(vals[3]);
      f.month  = 8'(vals[4]);
      f.year   = 8'(vals[5]);
      return f;
   endfunction

   // Drive one transaction, wait for acceptance, then maybe open a gap
   task automatic send_fields(input clock_fields_type f, input logic has_known,
                              input logic [33:0] known);
      int gap;
      start          <= 1'b1;
      req_raw_second <= f.second;
      req_raw_minute <= f.minute;
      req_raw_hour   <= f.hour;
      req_raw_day    <= f.day;
      req_raw_month  <= f.month;
      req_raw_year   <= f.year;
      known_valid    <= has_known;
      known_epoch    <= known;
      do begin
         @(posedge clock);
      end while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         // occasional long stretch without idling
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
      end
   endtask

   // Quiet the input, drain the pipeline, then write the mode register
   task automatic write_mode(input logic binary);
      start <= 1'b0;
      @(posedge clock);
      while (pending_epochs.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= binary;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Scoreboard: check results, record accepted transactions, track mode
   always @(posedge clock) begin
      logic [33:0] want;
      if (reset) begin
         binary_shadow = MODE_BCD;
      end else begin
         if (rsp_valid) begin
            if (pending_epochs.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, rsp_epoch_seconds);
               mismatch_count++;
            end else begin
               want = pending_epochs.pop_front();
               if (rsp_epoch_seconds !== want) begin
                  $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                           $time, want, rsp_epoch_seconds);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            if (known_valid) begin
               pending_epochs.push_back(known_epoch);
            end else begin
               pending_epochs.push_back(epoch_of_fields(binary_shadow,
                  clock_fields_type'({req_raw_second, req_raw_minute, req_raw_hour,
                                      req_raw_day, req_raw_month, req_raw_year})));
            end
         end
         if (csr_we) begin
            binary_shadow = csr_wdata;
         end
      end
   end

   // Stimulus: directed table, then random phases alternating the mode
   initial begin
      logic mode;
      int   drain_count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      mode = MODE_BCD;
      write_mode(mode);

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (DIRECTED[r].binary != mode) begin
            mode = DIRECTED[r].binary;
            write_mode(mode);
         end
         send_fields(DIRECTED[r].fields, DIRECTED[r].has_known, DIRECTED[r].known_epoch);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         mode = (p % 2 == 0) ? MODE_BCD : MODE_BINARY;
         write_mode(mode);
         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_fields(random_fields(mode), 1'b0, '0);
         end
      end

      start <= 1'b0;
      drain_count = 0;
      while (pending_epochs.size() != 0 && drain_count < 1000) begin
         @(posedge clock);
         drain_count++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_epochs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (pending_epochs.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_epochs.size());
         end
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
